@@ hdl/dpbp_pkg.sv @@
`default_nettype none
package dpbp_pkg;

  localparam int FMT_W   = 3;
  localparam int IMG_W_W = 13;
  localparam int RESET_IMG_W = 128;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [FMT_W-1:0] FMT_MONO1 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_GRAY4 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_GRAY8 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGB   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_BGR   = 3'd4;
  localparam logic [FMT_W-1:0] FMT_ARGB  = 3'd5;
  localparam logic [FMT_W-1:0] FMT_ABGR  = 3'd6;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  localparam logic [7:0] BYTE_MASK = 8'hFF;
  localparam logic [3:0] NIB_MASK  = 4'h0F;

  typedef struct packed {
    logic       mono_bit;
    logic [7:0] gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } pix_t;

  // Up to four bytes per pixel; last applies to the final byte of the job.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            last;
  } job_t;

endpackage
`default_nettype wire

@@ hdl/dpbp_ifs.sv @@
`default_nettype none
interface dpbp_pix_if;
  logic       valid;
  logic       ready;
  logic       mono_bit;
  logic [7:0] gray;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_pixel;

  modport source (output valid, mono_bit, gray, red, green, blue, alpha, last_pixel,
                  input ready);
  modport sink (input valid, mono_bit, gray, red, green, blue, alpha, last_pixel,
                output ready);
endinterface

interface dpbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/dpbp_front.sv @@
`default_nettype none
module dpbp_front #(
  parameter int CW_W = 13
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clr,
  input  wire logic [2:0]             fmt,
  input  wire logic [CW_W-1:0]        eff_width,
  input  wire logic                   pix_valid,
  output logic                        pix_ready,
  input  wire dpbp_pkg::pix_t         pix,
  output logic                        job_valid,
  input  wire logic                   job_ready,
  output dpbp_pkg::job_t              job
);
  import dpbp_pkg::*;

  logic [7:0]      acc_r, acc_nxt;
  logic [2:0]      held_r, held_nxt;
  logic [CW_W-1:0] col_r, col_nxt;
  logic [3:0]      nib_r, nib_nxt;
  logic            nib_wait_r, nib_wait_nxt;

  logic [CW_W-1:0] col_inc;
  logic            row_end;
  logic [7:0]      acc_set;
  logic [3:0]      nib;
  logic            fire;

  assign pix_ready = job_ready;
  assign fire      = pix_valid && pix_ready;
  assign col_inc   = col_r + 1'b1;
  assign row_end   = col_inc >= eff_width;
  assign acc_set   = acc_r | (pix.mono_bit ? (8'h80 >> held_r) : 8'h00);
  assign nib       = pix.gray[7:4] & NIB_MASK;

  always_comb begin
    acc_nxt      = acc_r;
    held_nxt     = held_r;
    col_nxt      = col_r;
    nib_nxt      = nib_r;
    nib_wait_nxt = nib_wait_r;
    job          = '0;
    job.last     = pix.last_pixel;
    job_valid    = 1'b0;
    if (fire) begin
      unique case (fmt)
        FMT_MONO1: begin
          acc_nxt  = acc_set;
          held_nxt = held_r + 1'b1;
          col_nxt  = row_end ? '0 : col_inc;
          if (held_r == 3'd7 || row_end || pix.last_pixel) begin
            job.bytes[0] = acc_set;
            job.cnt      = 3'd1;
            acc_nxt      = '0;
            held_nxt     = '0;
          end
        end
        FMT_GRAY4: begin
          if (nib_wait_r) begin
            job.bytes[0] = {nib_r, nib};
            job.cnt      = 3'd1;
            nib_wait_nxt = 1'b0;
            nib_nxt      = '0;
          end else if (pix.last_pixel) begin
            job.bytes[0] = {nib, 4'h0};
            job.cnt      = 3'd1;
          end else begin
            nib_nxt      = nib;
            nib_wait_nxt = 1'b1;
          end
        end
        FMT_GRAY8: begin
          job.bytes[0] = pix.gray & BYTE_MASK;
          job.cnt      = 3'd1;
        end
        FMT_RGB: begin
          job.bytes = {8'h00, pix.blue, pix.green, pix.red};
          job.cnt   = 3'd3;
        end
        FMT_BGR: begin
          job.bytes = {8'h00, pix.red, pix.green, pix.blue};
          job.cnt   = 3'd3;
        end
        FMT_ARGB: begin
          job.bytes = {pix.alpha, pix.red, pix.green, pix.blue};
          job.cnt   = 3'd4;
        end
        FMT_ABGR: begin
          job.bytes = {pix.alpha, pix.blue, pix.green, pix.red};
          job.cnt   = 3'd4;
        end
        default: job.cnt = 3'd0;
      endcase
      job_valid = job.cnt != 3'd0;
      if (pix.last_pixel) begin
        acc_nxt      = '0;
        held_nxt     = '0;
        col_nxt      = '0;
        nib_nxt      = '0;
        nib_wait_nxt = 1'b0;
      end
    end
    if (clr) begin
      acc_nxt      = '0;
      held_nxt     = '0;
      col_nxt      = '0;
      nib_nxt      = '0;
      nib_wait_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      held_r     <= '0;
      col_r      <= '0;
      nib_r      <= '0;
      nib_wait_r <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      held_r     <= held_nxt;
      col_r      <= col_nxt;
      nib_r      <= nib_nxt;
      nib_wait_r <= nib_wait_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dpbp_queue.sv @@
`default_nettype none
module dpbp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire dpbp_pkg::job_t push_job,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output dpbp_pkg::job_t      pop_job
);
  import dpbp_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_job    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dpbp_back.sv @@
`default_nettype none
module dpbp_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire dpbp_pkg::job_t job,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import dpbp_pkg::*;

  job_t       cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       ol_r, ol_nxt;
  logic       ld, at_end, free;
  logic [1:0] last_idx;

  assign last_idx  = cur_r.cnt[1:0] - 2'd1;
  assign ld        = !ov_r || out_ready;
  assign at_end    = idx_r == last_idx;
  assign free      = !busy_r || (ld && at_end);
  assign job_ready = free;
  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    if (ld) begin
      ov_nxt = busy_r;
      if (busy_r) begin
        ob_nxt  = cur_r.bytes[idx_r];
        ol_nxt  = cur_r.last && at_end;
        idx_nxt = idx_r + 2'd1;
        if (at_end) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (free && job_valid) begin
      cur_nxt  = job;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/display_pixel_byte_packer.sv @@
// Pixel to wire-byte packer. One pixel per input transaction, one byte per
// output transaction. A pixel yields four bytes in ARGB8888/ABGR8888 and three
// in RGB888/BGR888. Gray8, gray4, mono1 and the undefined format (no bytes)
// run at one pixel per cycle unless the output stalls; gray4 yields one byte
// per two pixels (a lone last pixel yields one too) and mono1 one per eight
// (or at row end or last pixel). The byte-wide output register, at one byte
// per clock while not stalled, sets the pace. The front end packs pixels
// into jobs; a two-entry queue decouples it from the byte serializer.
// Any register write restarts the image; write registers only while idle.
// Register map: 0x0 pixel_format, 0x4 image_width.
`default_nettype none
module display_pixel_byte_packer #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  dpbp_pix_if.sink                           in_ch,
  dpbp_byte_if.source                        out_ch,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [dpbp_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire logic [dpbp_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [dpbp_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                               cfg_pready
);
  import dpbp_pkg::*;

  localparam int CW_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (CW_W > IMG_W_W) ? CW_W : IMG_W_W;
  localparam int RESET_EW = (RESET_IMG_W > MAX_WIDTH) ? MAX_WIDTH : RESET_IMG_W;

  logic [FMT_W-1:0]   fmt_r, fmt_nxt;
  logic [IMG_W_W-1:0] img_w_r, img_w_nxt;
  logic [CW_W-1:0]    ew_r, ew_nxt;
  logic               wr, clr;
  logic [CMP_W-1:0]   w_ext;

  pix_t pix;
  job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;

  assign cfg_pready = 1'b1;
  assign wr    = cfg_psel && cfg_penable && cfg_pwrite;
  assign clr   = wr;
  assign w_ext = CMP_W'(cfg_pwdata[IMG_W_W-1:0]);

  always_comb begin
    fmt_nxt   = fmt_r;
    img_w_nxt = img_w_r;
    ew_nxt    = ew_r;
    if (wr) begin
      unique case (cfg_paddr[2])
        REG_FORMAT: fmt_nxt = cfg_pwdata[FMT_W-1:0];
        REG_WIDTH: begin
          img_w_nxt = cfg_pwdata[IMG_W_W-1:0];
          if (w_ext == '0) begin
            ew_nxt = CW_W'(1);
          end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
            ew_nxt = CW_W'(MAX_WIDTH);
          end else begin
            ew_nxt = w_ext[CW_W-1:0];
          end
        end
        default: fmt_nxt = fmt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_MONO1;
      img_w_r <= IMG_W_W'(RESET_IMG_W);
      ew_r    <= CW_W'(RESET_EW);
    end else begin
      fmt_r   <= fmt_nxt;
      img_w_r <= img_w_nxt;
      ew_r    <= ew_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_FORMAT: cfg_prdata = DATA_W'(fmt_r);
      REG_WIDTH:  cfg_prdata = DATA_W'(img_w_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign pix.mono_bit   = in_ch.mono_bit;
  assign pix.gray       = in_ch.gray;
  assign pix.red        = in_ch.red;
  assign pix.green      = in_ch.green;
  assign pix.blue       = in_ch.blue;
  assign pix.alpha      = in_ch.alpha;
  assign pix.last_pixel = in_ch.last_pixel;

  dpbp_front #(.CW_W(CW_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .fmt       (fmt_r),
    .eff_width (ew_r),
    .pix_valid (in_ch.valid),
    .pix_ready (in_ch.ready),
    .pix       (pix),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  dpbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  dpbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_byte)
  );

endmodule
`default_nettype wire

@@ hdl/dpbp_checker.sv @@
`default_nettype none
module dpbp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [2:0]  cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  input wire logic [31:0] cfg_prdata,
  input wire logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output transaction dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_fmt_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2] |=>
      cfg_paddr[2] || cfg_prdata[2:0] == $past(cfg_pwdata[2:0]))
    else $error("pixel_format readback mismatch");

  a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] |=>
      !cfg_paddr[2] || cfg_prdata[12:0] == $past(cfg_pwdata[12:0]))
    else $error("image_width readback mismatch");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("config port stalled");

endmodule

bind display_pixel_byte_packer dpbp_checker u_dpbp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata),
  .cfg_pready  (cfg_pready)
);
`default_nettype wire
